@@ design/fit_pkg.sv @@
package fit_pkg;

  // default number of injection sites
  localparam int unsigned NumSitesDefault = 5;
  // sites that own a setup register
  localparam int unsigned SetupRegs = 5;

  localparam int unsigned CountW = 32;
  localparam int unsigned ParamW = 31;
  localparam int unsigned SiteW = 3;
  localparam int unsigned FlipW = 4;
  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;

  localparam logic [31:0] DefaultSeed = 32'hA5A5A5A5;
  localparam logic [FlipW-1:0] FlipReset = 4'd3;

  // register indexes in the configuration map
  localparam logic [2:0] CfgFlipCount = 3'd5;
  localparam logic [2:0] CfgRngSeed = 3'd6;

  // site policy codes
  localparam logic [1:0] PolEveryN = 2'd1;
  localparam logic [1:0] PolWindow = 2'd2;

  // reset setup per site: every 200, disabled, disabled, every 100, window 500 to 520
  localparam logic [63:0] SetupReset [SetupRegs] = '{
    64'd801, 64'd0, 64'd0, 64'd401, 64'd4466765989842
  };

  typedef struct packed {
    logic             action;
    logic [SiteW-1:0] site;
    logic [7:0]       data_in;
  } in_item_t;

  typedef struct packed {
    logic              fired;
    logic [7:0]        data_out;
    logic [CountW-1:0] hits_now;
    logic [CountW-1:0] fires_now;
  } out_item_t;

endpackage

@@ design/fault_injection_trigger.sv @@
// fault injection trigger for a set of injection sites
//
// input channel (in_valid_i / in_stall_o / in_data_i) carries one transaction per
// request: a hit on a site (action 0) or a byte to corrupt (action 1). every
// transaction yields exactly one result transaction on out_valid_o / out_stall_i /
// out_data_o, in order.
//
// a hit on an every-N site runs a bit-serial 32-bit remainder by the period through
// one shared subtract/compare unit, one bit per cycle, then ends in the final step.
// window, disabled and invalid-site hits go straight to the final step. a corrupt
// runs n xorshift32 steps, one per cycle, n = flip_count (zero counts as one).
//
// while a transaction is in work in_stall_o is high. the result sits in an output
// register; a stalled receiver holds it there, the next input transaction is still
// taken, and that one waits in its final step until the register is free.
// reset clears all hit and fire counts, loads the setup defaults and the default
// generator seed, and leaves the output register empty. config is APB, 64-bit data,
// register i at byte address 8*i, pready always high.
module fault_injection_trigger #(
  parameter int unsigned NUM_SITES = fit_pkg::NumSitesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fit_pkg::in_item_t    in_data_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fit_pkg::out_item_t   out_data_o,

  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [fit_pkg::AddrW-1:0] paddr,
  input  logic [fit_pkg::DataW-1:0] pwdata,
  output logic [fit_pkg::DataW-1:0] prdata,
  output logic                 pready
);
  import fit_pkg::*;

  localparam int unsigned IdxW = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
  localparam int unsigned ExtW = (IdxW > SiteW) ? IdxW : SiteW;
  localparam int unsigned StepW = $clog2(CountW);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_MOD  = 4'b0100,
    S_RNG  = 4'b1000
  } state_e;
  // final step shares the eval code path through fin_q

  state_e state_q, state_d;
  logic   fin_q;

  // configuration
  logic [63:0]       setup_q [SetupRegs];
  logic [FlipW-1:0]  flip_q;
  logic [31:0]       seed_q;
  logic [31:0]       rng_q;

  // per-site counters
  logic [CountW-1:0] hit_q  [NUM_SITES];
  logic [CountW-1:0] fire_q [NUM_SITES];

  // transaction in work
  logic              action_q;
  logic [SiteW-1:0]  site_q;
  logic [7:0]        byte_q;
  logic              fired_q;

  // remainder datapath
  logic [CountW-1:0] div_q;
  logic [ParamW-1:0] rem_q;
  logic [StepW-1:0]  step_q;
  logic [FlipW-1:0]  iter_q;

  // result register
  logic              out_valid_q;
  out_item_t         out_q;

  logic              cfg_wr;
  logic [2:0]        cfg_idx;
  logic              in_acc;
  logic [ExtW-1:0]   in_site_ext, site_ext;
  logic [IdxW-1:0]   in_idx, site_idx;
  logic              in_site_ok, site_ok;
  logic [63:0]       setup_sel;
  logic [1:0]        policy;
  logic [ParamW-1:0] lowp, highp;
  logic [CountW-1:0] cnt_cur, fire_cur;
  logic [CountW-1:0] shifted;
  logic              sub_ok;
  logic [CountW-1:0] sub_res;
  logic              out_free;
  logic              win_hit;
  logic [31:0]       rng_next;
  logic [FlipW-1:0]  flips;

  function automatic logic [31:0] xorshift(input logic [31:0] v);
    logic [31:0] x;
    x = v ^ (v << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[AddrW-1:3];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign in_site_ext = ExtW'(in_data_i.site);
  assign in_idx      = in_site_ext[IdxW-1:0];
  assign in_site_ok  = (32'(in_data_i.site) < NUM_SITES);

  assign site_ext = ExtW'(site_q);
  assign site_idx = site_ext[IdxW-1:0];
  assign site_ok  = (32'(site_q) < NUM_SITES);

  // sites past the setup registers act as disabled
  assign setup_sel = (site_ok && (32'(site_q) < SetupRegs)) ? setup_q[site_q] : 64'd0;
  assign policy    = setup_sel[1:0];
  assign lowp      = setup_sel[32:2];
  assign highp     = setup_sel[63:33];

  assign cnt_cur  = site_ok ? hit_q[site_idx]  : '0;
  assign fire_cur = site_ok ? fire_q[site_idx] : '0;

  // shared subtract/compare unit: one restoring remainder step
  assign shifted = {rem_q, div_q[CountW-1]};
  assign sub_res = shifted - CountW'(lowp);
  assign sub_ok  = (shifted >= CountW'(lowp));

  assign win_hit  = (cnt_cur >= CountW'(lowp)) && (cnt_cur < CountW'(highp));
  assign rng_next = xorshift(rng_q);
  assign flips    = (flip_q == '0) ? FlipW'(1) : flip_q;
  assign out_free = ~out_valid_q | ~out_stall_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (fin_q) begin
          if (out_free) state_d = S_IDLE;
        end else if (action_q) begin
          state_d = S_RNG;
        end else if (site_ok && policy == PolEveryN && lowp != '0) begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (step_q == StepW'(CountW - 1)) state_d = S_EVAL;
      end
      S_RNG: begin
        if (iter_q == FlipW'(1)) state_d = S_EVAL;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      flip_q      <= FlipReset;
      seed_q      <= '0;
      rng_q       <= DefaultSeed;
      for (int i = 0; i < SetupRegs; i++) setup_q[i] <= SetupReset[i];
      for (int i = 0; i < NUM_SITES; i++) begin
        hit_q[i]  <= '0;
        fire_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      // a new result loads in the final step, otherwise a taken result empties
      if (out_valid_q && !out_stall_i && !(state_q == S_EVAL && fin_q)) out_valid_q <= 1'b0;

      // register writes
      if (cfg_wr) begin
        if (32'(cfg_idx) < SetupRegs) begin
          if (32'(cfg_idx) < NUM_SITES) setup_q[cfg_idx] <= pwdata;
        end else if (cfg_idx == CfgFlipCount) begin
          flip_q <= pwdata[FlipW-1:0];
        end else if (cfg_idx == CfgRngSeed) begin
          seed_q <= pwdata[31:0];
          rng_q  <= (pwdata[31:0] == '0) ? DefaultSeed : pwdata[31:0];
        end
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            fin_q <= 1'b0;
            // the hit count moves on acceptance
            if (!in_data_i.action && in_site_ok) hit_q[in_idx] <= hit_q[in_idx] + 1'b1;
          end
        end
        S_EVAL: begin
          if (fin_q) begin
            if (out_free) begin
              out_valid_q <= 1'b1;
              if (fired_q) fire_q[site_idx] <= fire_q[site_idx] + 1'b1;
            end
          end else begin
            fin_q <= action_q || !(site_ok && policy == PolEveryN && lowp != '0);
          end
        end
        S_MOD: begin
          if (step_q == StepW'(CountW - 1)) fin_q <= 1'b1;
        end
        S_RNG: begin
          rng_q <= rng_next;
          if (iter_q == FlipW'(1)) fin_q <= 1'b1;
        end
        default: begin
          fin_q <= 1'b0;
        end
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          action_q <= in_data_i.action;
          site_q   <= in_data_i.site;
          byte_q   <= in_data_i.data_in;
        end
      end
      S_EVAL: begin
        if (!fin_q) begin
          div_q   <= cnt_cur;
          rem_q   <= '0;
          step_q  <= '0;
          iter_q  <= flips;
          fired_q <= !action_q && site_ok && policy == PolWindow && win_hit;
        end else if (out_free) begin
          out_q.fired     <= fired_q;
          out_q.data_out  <= action_q ? byte_q : 8'd0;
          out_q.hits_now  <= cnt_cur;
          out_q.fires_now <= fire_cur + CountW'(fired_q);
        end
      end
      S_MOD: begin
        rem_q  <= sub_ok ? sub_res[ParamW-1:0] : shifted[ParamW-1:0];
        div_q  <= {div_q[CountW-2:0], 1'b0};
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(CountW - 1)) begin
          fired_q <= sub_ok ? (sub_res == '0) : (shifted == '0);
        end
      end
      S_RNG: begin
        byte_q <= byte_q ^ (8'd1 << rng_next[2:0]);
        iter_q <= iter_q - 1'b1;
      end
      default: begin
        fired_q <= 1'b0;
      end
    endcase
  end

  // register read back
  always_comb begin
    prdata = '0;
    if (32'(cfg_idx) < SetupRegs) begin
      if (32'(cfg_idx) < NUM_SITES) prdata = setup_q[cfg_idx];
    end else if (cfg_idx == CfgFlipCount) begin
      prdata = DataW'(flip_q);
    end else if (cfg_idx == CfgRngSeed) begin
      prdata = DataW'(seed_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // an accepted transaction always moves the sequencer into evaluation
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_EVAL && !fin_q))
    else $error("accepted transaction did not enter evaluation");

  // the partial remainder stays below the period
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> (rem_q < lowp))
    else $error("remainder out of range");

  // the last remainder step hands over to the final step
  a_mod_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && step_q == StepW'(CountW - 1)) |=> (state_q == S_EVAL && fin_q))
    else $error("remainder sequence did not finish");

  // a fire never comes with a corrupted byte
  a_fire_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.fired) |-> (out_q.data_out == 8'd0))
    else $error("fire reported on a corrupt transaction");
`endif

endmodule
